FILE: hdl/first_fit_heap_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that holds whenever its antecedent holds.
`define FFHA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/ffha_pkg.sv
// Types, constants and helper functions of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int OFF_W      = 24;
    localparam int LEN_W      = OFF_W + 1;
    localparam int ADDR_W     = 32;
    localparam int REQ_W      = 24;
    localparam int ALIGN_W    = 8;
    localparam int ADJ_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 6;
    localparam int HDR_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAX_FREE_SEGMENTS = 16;
    localparam int DEF_MAX_LIVE_BLOCKS   = 32;
    localparam int DEF_HEADER_BYTES      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_RSCAN, S_SSCAN, S_ALLOC_WR, S_REL_DEC, S_REL_WR,
        S_SHDN, S_SHUP, S_INS, S_DONE
    } t_state;

    // One free segment, offset relative to the region base.
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [LEN_W-1:0] len;
    } t_seg;

    // One live block record.
    typedef struct packed {
        logic [OFF_W-1:0] addr;
        logic [LEN_W-1:0] len;
        logic [ADJ_W-1:0] adj;
    } t_rec;

    // Largest power of two not above v; zero maps to one.
    function automatic logic [ALIGN_W-1:0] pow2_floor(input logic [ALIGN_W-1:0] v);
        logic [ALIGN_W-1:0] p;
        p = ALIGN_W'(1);
        for (int i = 0; i < ALIGN_W; i++) begin
            if (v[i]) begin
                p = ALIGN_W'(1) << i;
            end
        end
        return p;
    endfunction

    // Padding in front of a block: aligns the address and leaves room for the header.
    function automatic logic [ADJ_W:0] fit_adjust(input logic [7:0] lo,
                                                  input logic [ALIGN_W-1:0] align,
                                                  input logic [HDR_W-1:0] hdr);
        logic [7:0] mask;
        logic [7:0] adj0;
        logic [7:0] need;
        logic [8:0] up;
        mask = align - 8'd1;
        adj0 = (8'd0 - lo) & mask;
        need = 8'd0;
        up   = 9'd0;
        if (adj0 < {1'b0, hdr}) begin
            need = {1'b0, hdr} - adj0;
            up   = ({1'b0, need} + {1'b0, mask}) & ~{1'b0, mask};
        end
        return {1'b0, adj0} + up;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ffha_req_if.sv
// Request channel: one allocate or release item per beat.
`default_nettype none
interface ffha_req_if import ffha_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [REQ_W-1:0]      request_bytes;
    logic [ALIGN_W-1:0]    align_bytes;
    logic [ADDR_W-1:0]     release_address;

    modport source (output valid, op, request_bytes, align_bytes, release_address,
                    input ready);
    modport sink   (input valid, op, request_bytes, align_bytes, release_address,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/ffha_res_if.sv
// Result channel: one result per request beat.
`default_nettype none
interface ffha_res_if import ffha_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ADDR_W-1:0]     granted_address;
    logic [STATUS_W-1:0]   status;
    logic [LEN_W-1:0]      bytes_in_use;
    logic [LIVE_W-1:0]     live_count;

    modport source (output valid, granted_address, status, bytes_in_use, live_count,
                    input ready);
    modport sink   (input valid, granted_address, status, bytes_in_use, live_count,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/ffha_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module ffha_ram import ffha_pkg::*; #(
    parameter int WIDTH = LEN_W,
    parameter int DEPTH = DEF_MAX_FREE_SEGMENTS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with control sequencer and table memories.
//
// Keeps the free segments of one heap region address-sorted in a segment RAM and
// the live blocks in a record RAM. An item runs a scan of the record RAM, one
// entry per cycle, and, when that scan finds its record or free slot, a scan of
// the segment RAM, one entry per cycle, then one or two update states and, when
// a segment is removed or inserted, a shift of the following segments at one
// entry per cycle through the segment RAM's read and write ports. The result
// waits in the final state until the previous result beat has drained. After
// reset and after every configuration write the block rewrites the first segment
// in its init state before it accepts a request beat. Results are registered, so
// a new request is taken while the previous result beat still waits on the output.
`default_nettype none
`include "first_fit_heap_allocator_assert.svh"
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int MAX_FREE_SEGMENTS = DEF_MAX_FREE_SEGMENTS,
    parameter int MAX_LIVE_BLOCKS   = DEF_MAX_LIVE_BLOCKS,
    parameter int HEADER_BYTES      = DEF_HEADER_BYTES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ffha_req_if.sink                   i_req,
    ffha_res_if.source                 o_res
);

    localparam int SW  = $clog2(MAX_FREE_SEGMENTS);
    localparam int CW  = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int RW  = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;
    localparam int RCW = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam logic [HDR_W-1:0] HDR = HDR_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(1) << OFF_W;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_base;
    logic [LEN_W-1:0]    r_size;
    logic                r_op;
    logic [REQ_W-1:0]    r_req;
    logic [ALIGN_W-1:0]  r_align;
    logic [ADDR_W-1:0]   r_off;
    logic [MAX_LIVE_BLOCKS-1:0] r_valid;
    logic [RCW-1:0]      r_ridx;
    logic                r_rp_vld;
    logic [RW-1:0]       r_rp_idx;
    logic [RW-1:0]       r_rec_idx;
    logic [CW-1:0]       r_sidx, r_sp_idx, r_count, r_pos;
    logic                r_sp_vld;
    logic [OFF_W-1:0]    r_start, r_bstart, r_gofs;
    logic [LEN_W-1:0]    r_len, r_total, r_bsize, r_bend, r_sum_p, r_sum_n;
    logic [ADJ_W-1:0]    r_adj;
    t_seg                r_prev, r_cur;
    logic                r_jp, r_jn;
    logic [CW-1:0]       r_src, r_dst, r_pdst;
    logic                r_issue, r_pend;
    t_status             r_status;
    logic [LEN_W-1:0]    r_used;
    logic [RCW-1:0]      r_live;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_o_addr;
    t_status             r_o_status;
    logic [LEN_W-1:0]    r_o_used;
    logic [LIVE_W-1:0]   r_o_live;

    t_seg                seg_q, seg_wdata;
    t_rec                rec_q, rec_wdata;
    logic                seg_we, rec_we;
    logic [SW-1:0]       seg_waddr, seg_raddr;

    logic [ADJ_W:0]      c_adj_full;
    logic [ADJ_W-1:0]    c_adj;
    logic [LEN_W-1:0]    c_total, c_rem, c_take, c_init_len;
    logic                c_split, seg_hit, seg_end, rec_hit, rec_end, shift_done;
    logic                c_jp, c_jn, accept;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Memories for the free segments and the live records.
    ffha_ram #(.WIDTH($bits(t_seg)), .DEPTH(MAX_FREE_SEGMENTS), .AW(SW)) u_seg_ram (
        .i_clk  (i_clk),
        .i_we   (seg_we),
        .i_waddr(seg_waddr),
        .i_wdata(seg_wdata),
        .i_raddr(seg_raddr),
        .o_rdata(seg_q)
    );

    ffha_ram #(.WIDTH($bits(t_rec)), .DEPTH(MAX_LIVE_BLOCKS), .AW(RW)) u_rec_ram (
        .i_clk  (i_clk),
        .i_we   (rec_we),
        .i_waddr(r_rec_idx),
        .i_wdata(rec_wdata),
        .i_raddr(r_ridx[RW-1:0]),
        .o_rdata(rec_q)
    );

    // Fit test of the segment read last cycle.
    always_comb begin
        c_adj_full = fit_adjust(r_base[7:0] + seg_q.start[7:0], r_align, HDR);
        c_adj      = c_adj_full[ADJ_W-1:0];
        c_total    = LEN_W'(r_req) + LEN_W'(c_adj);
        seg_hit    = r_sp_vld && ((r_op == OP_ALLOC) ? (c_total <= seg_q.len)
                                                     : ({1'b0, seg_q.start} >= r_bend));
        seg_end    = !seg_hit && (r_sidx >= r_count);
        rec_hit    = r_rp_vld && ((r_op == OP_ALLOC) ? !r_valid[r_rp_idx]
                                 : (r_valid[r_rp_idx] && (ADDR_W'(rec_q.addr) == r_off)));
        rec_end    = !rec_hit && (r_ridx >= RCW'(MAX_LIVE_BLOCKS));
        c_rem      = r_len - r_total;
        c_split    = c_rem > LEN_W'(HEADER_BYTES);
        c_take     = c_split ? r_total : r_len;
        c_jp       = (r_pos != '0) &&
                     ((LEN_W'(r_prev.start) + r_prev.len) == LEN_W'(r_bstart));
        c_jn       = (r_pos < r_count) && (LEN_W'(r_cur.start) == r_bend);
        shift_done = !r_issue && !r_pend;
        c_init_len = (r_size > LEN_LIMIT) ? LEN_LIMIT : r_size;
    end

    // Memory write and read controls.
    always_comb begin
        seg_we    = 1'b0;
        seg_waddr = r_pos[SW-1:0];
        seg_wdata = '{start: r_bstart, len: r_bsize};
        seg_raddr = r_sidx[SW-1:0];
        rec_we    = 1'b0;
        rec_wdata = '{addr: r_start + OFF_W'(r_adj), len: c_take, adj: r_adj};
        case (r_state)
            S_INIT: begin
                seg_we    = 1'b1;
                seg_waddr = '0;
                seg_wdata = '{start: '0, len: c_init_len};
            end
            S_ALLOC_WR: begin
                rec_we    = 1'b1;
                seg_we    = c_split;
                seg_wdata = '{start: r_start + r_total[OFF_W-1:0], len: c_rem};
            end
            S_REL_WR: begin
                if (r_jp) begin
                    seg_we    = 1'b1;
                    seg_waddr = SW'(r_pos - CW'(1));
                    seg_wdata = '{start: r_prev.start,
                                  len: r_jn ? (r_sum_p + r_cur.len) : r_sum_p};
                end else if (r_jn) begin
                    seg_we    = 1'b1;
                    seg_wdata = '{start: r_bstart, len: r_sum_n};
                end
            end
            S_SHDN, S_SHUP: begin
                seg_raddr = r_src[SW-1:0];
                seg_we    = r_pend;
                seg_waddr = r_pdst[SW-1:0];
                seg_wdata = seg_q;
            end
            S_INS: begin
                seg_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:     n_state = S_IDLE;
            S_IDLE:     if (accept) n_state = S_RSCAN;
            S_RSCAN: begin
                if (rec_hit) n_state = S_SSCAN;
                else if (rec_end) n_state = S_DONE;
            end
            S_SSCAN: begin
                if (seg_hit) n_state = (r_op == OP_ALLOC) ? S_ALLOC_WR : S_REL_DEC;
                else if (seg_end) n_state = (r_op == OP_ALLOC) ? S_DONE : S_REL_DEC;
            end
            S_ALLOC_WR: n_state = c_split ? S_DONE : S_SHDN;
            S_REL_DEC:  n_state = S_REL_WR;
            S_REL_WR: begin
                if (r_jp && r_jn) n_state = S_SHDN;
                else if (r_jp || r_jn) n_state = S_DONE;
                else if (r_count >= CW'(MAX_FREE_SEGMENTS)) n_state = S_DONE;
                else if (r_pos < r_count) n_state = S_SHUP;
                else n_state = S_INS;
            end
            S_SHDN:     if (shift_done) n_state = S_DONE;
            S_SHUP:     if (shift_done) n_state = S_INS;
            S_INS:      n_state = S_DONE;
            S_DONE:     if (!r_out_valid || o_res.ready) n_state = S_IDLE;
            default:    n_state = S_INIT;
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Control counters, bookkeeping and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= LEN_LIMIT;
            r_valid     <= '0;
            r_used      <= '0;
            r_live      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rp_vld    <= 1'b0;
            r_sp_vld    <= 1'b0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            // The final state loads the next beat itself, so the drain is handled there.
            if (r_out_valid && o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_count <= (r_size == '0) ? CW'(0) : CW'(1);
                end
                S_IDLE: begin
                    r_op     <= i_req.op;
                    r_req    <= (i_req.request_bytes == '0) ? REQ_W'(1) : i_req.request_bytes;
                    r_align  <= pow2_floor(i_req.align_bytes);
                    r_off    <= i_req.release_address - r_base;
                    r_ridx   <= '0;
                    r_rp_vld <= 1'b0;
                end
                S_RSCAN: begin
                    // Pipelined record scan: issue one read, check the previous one.
                    r_rp_vld <= (r_ridx < RCW'(MAX_LIVE_BLOCKS));
                    r_rp_idx <= r_ridx[RW-1:0];
                    if (r_ridx < RCW'(MAX_LIVE_BLOCKS)) begin
                        r_ridx <= r_ridx + RCW'(1);
                    end
                    if (rec_hit) begin
                        r_rec_idx <= r_rp_idx;
                        r_bstart  <= rec_q.addr - OFF_W'(rec_q.adj);
                        r_bsize   <= rec_q.len;
                        r_sidx    <= '0;
                        r_sp_vld  <= 1'b0;
                    end else if (rec_end) begin
                        r_status <= (r_op == OP_ALLOC) ? ST_FULL : ST_UNKNOWN;
                    end
                end
                S_SSCAN: begin
                    // Pipelined segment scan in address order.
                    r_bend   <= LEN_W'(r_bstart) + r_bsize;
                    r_sp_vld <= (r_sidx < r_count);
                    r_sp_idx <= r_sidx;
                    if (r_sidx < r_count) begin
                        r_sidx <= r_sidx + CW'(1);
                    end
                    if (seg_hit) begin
                        r_pos   <= r_sp_idx;
                        r_cur   <= seg_q;
                        r_start <= seg_q.start;
                        r_len   <= seg_q.len;
                        r_total <= c_total;
                        r_adj   <= c_adj;
                    end else begin
                        if (r_sp_vld) begin
                            r_prev <= seg_q;
                        end
                        if (seg_end) begin
                            r_pos    <= r_count;
                            r_status <= ST_NOFIT;
                        end
                    end
                end
                S_ALLOC_WR: begin
                    r_valid[r_rec_idx] <= 1'b1;
                    r_used   <= r_used + c_take;
                    r_live   <= r_live + RCW'(1);
                    r_gofs   <= r_start + OFF_W'(r_adj);
                    r_status <= ST_OK;
                    r_src    <= r_pos + CW'(1);
                    r_dst    <= r_pos;
                    r_issue  <= ((r_pos + CW'(1)) < r_count);
                    r_pend   <= 1'b0;
                end
                S_REL_DEC: begin
                    r_jp    <= c_jp;
                    r_jn    <= c_jn;
                    r_sum_p <= r_prev.len + r_bsize;
                    r_sum_n <= r_cur.len + r_bsize;
                end
                S_REL_WR: begin
                    if (!r_jp && !r_jn && (r_count >= CW'(MAX_FREE_SEGMENTS))) begin
                        r_status <= ST_FULL;
                    end else begin
                        r_valid[r_rec_idx] <= 1'b0;
                        r_used   <= r_used - r_bsize;
                        r_live   <= r_live - RCW'(1);
                        r_status <= ST_OK;
                    end
                    r_pend <= 1'b0;
                    if (r_jp && r_jn) begin
                        r_src   <= r_pos + CW'(1);
                        r_dst   <= r_pos;
                        r_issue <= ((r_pos + CW'(1)) < r_count);
                    end else begin
                        r_src   <= r_count - CW'(1);
                        r_dst   <= r_count;
                        r_issue <= (r_pos < r_count);
                    end
                end
                S_SHDN: begin
                    // Move segments one place down after a removal.
                    r_pend <= r_issue;
                    if (r_issue) begin
                        r_pdst  <= r_dst;
                        r_src   <= r_src + CW'(1);
                        r_dst   <= r_dst + CW'(1);
                        r_issue <= ((r_src + CW'(1)) < r_count);
                    end
                    if (shift_done) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                S_SHUP: begin
                    // Move segments one place up to open a slot.
                    r_pend <= r_issue;
                    if (r_issue) begin
                        r_pdst  <= r_dst;
                        r_src   <= r_src - CW'(1);
                        r_dst   <= r_dst - CW'(1);
                        r_issue <= (r_src != r_pos);
                    end
                end
                S_INS: begin
                    r_count <= r_count + CW'(1);
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_o_addr    <= ((r_op == OP_ALLOC) && (r_status == ST_OK))
                                       ? (r_base + ADDR_W'(r_gofs)) : '0;
                        r_o_status  <= r_status;
                        r_o_used    <= r_used;
                        r_o_live    <= LIVE_W'(r_live);
                    end
                end
                default: begin
                end
            endcase
            // Configuration writes reinitialize the heap.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REGION_BASE: r_base <= i_cfg_data;
                    CFG_REGION_SIZE: r_size <= i_cfg_data[LEN_W-1:0];
                    default: begin
                    end
                endcase
                r_valid <= '0;
                r_used  <= '0;
                r_live  <= '0;
            end
        end
    end

    // Result beat.
    assign o_res.valid           = r_out_valid;
    assign o_res.granted_address = r_o_addr;
    assign o_res.status          = r_o_status;
    assign o_res.bytes_in_use    = r_o_used;
    assign o_res.live_count      = r_o_live;

    // Consistency of the bookkeeping.
    `FFHA_ASSERT_ALWAYS(a_live_matches_valid, i_clk, i_rst_n,
        r_live == $countones(r_valid), "live count differs from valid records")
    `FFHA_ASSERT_IMPLY(a_no_live_no_bytes, i_clk, i_rst_n,
        r_live == '0, r_used == '0, "bytes in use without live blocks")
    `FFHA_ASSERT_ALWAYS(a_seg_count_bound, i_clk, i_rst_n,
        r_count <= CW'(MAX_FREE_SEGMENTS), "segment count above table size")

endmodule
`default_nettype wire

FILE: bench/heap_predictor_check.sv
// Checker that predicts the allocator's replies and compares them with the result channel.
`timescale 1ns / 100ps
`default_nettype none
module heap_predictor_check import ffha_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ffha_req_if                        i_req,
    ffha_res_if                        i_res,
    output int                         o_pending,
    output int                         o_errors
);

    localparam int NSEG = DEF_MAX_FREE_SEGMENTS;
    localparam int NREC = DEF_MAX_LIVE_BLOCKS;
    localparam int HDR  = DEF_HEADER_BYTES;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           status;
        logic [LEN_W-1:0]  in_use;
        logic [LIVE_W-1:0] live;
    } t_heap_reply;

    // Shadow copy of the heap tables.
    logic [31:0]      heap_base;
    logic [24:0]      heap_size;
    longint           free_start [NSEG];
    longint           free_len   [NSEG];
    int               free_count;
    longint           blk_addr   [NREC];
    longint           blk_len    [NREC];
    longint           blk_adj    [NREC];
    bit               blk_live   [NREC];
    longint           bytes_held;
    int               blocks_held;
    t_heap_reply      expected_replies[$];

    assign o_pending = expected_replies.size();

    function automatic void rebuild_heap();
        longint sz;
        sz = heap_size;
        if (sz > (64'd1 << OFF_W)) sz = 64'd1 << OFF_W;
        for (int k = 0; k < NSEG; k++) begin
            free_start[k] = 0;
            free_len[k]   = 0;
        end
        for (int k = 0; k < NREC; k++) blk_live[k] = 1'b0;
        free_count  = (sz == 0) ? 0 : 1;
        free_len[0] = sz;
        bytes_held  = 0;
        blocks_held = 0;
    endfunction

    function automatic void drop_segment(int idx);
        for (int k = idx; k + 1 < free_count; k++) begin
            free_start[k] = free_start[k+1];
            free_len[k]   = free_len[k+1];
        end
        free_count--;
    endfunction

    function automatic t_heap_reply make_reply(logic [31:0] addr, t_status st);
        t_heap_reply rep;
        rep.addr   = addr;
        rep.status = st;
        rep.in_use = bytes_held[24:0];
        rep.live   = blocks_held[5:0];
        return rep;
    endfunction

    // First-fit allocation with header and alignment padding.
    function automatic t_heap_reply predict_alloc(logic [23:0] req_in, logic [7:0] align_in);
        longint req, align, total, adj, need;
        logic [31:0] abs_addr;
        int slot;
        req = (req_in == 0) ? 1 : req_in;
        align = 1;
        while (align <= (align_in >> 1)) align = align << 1;
        slot = -1;
        for (int r = NREC - 1; r >= 0; r--) if (!blk_live[r]) slot = r;
        if (slot < 0) return make_reply('0, ST_FULL);
        for (int i = 0; i < free_count; i++) begin
            abs_addr = heap_base + 32'(free_start[i]);
            adj = (align - (abs_addr & 32'(align - 1))) & (align - 1);
            if (adj < HDR) begin
                need = HDR - adj;
                adj += align * (need / align);
                if (need % align != 0) adj += align;
            end
            total = req + adj;
            if (total > free_len[i]) continue;
            blk_addr[slot] = free_start[i] + adj;
            blk_adj[slot]  = adj;
            if (free_len[i] - total > HDR) begin
                free_start[i] += total;
                free_len[i]   -= total;
            end else begin
                total = free_len[i];
                drop_segment(i);
            end
            blk_live[slot] = 1'b1;
            blk_len[slot]  = total;
            bytes_held += total;
            blocks_held++;
            return make_reply(heap_base + 32'(blk_addr[slot]), ST_OK);
        end
        return make_reply('0, ST_NOFIT);
    endfunction

    // Release with coalescing into the sorted free list.
    function automatic t_heap_reply predict_release(logic [31:0] rel);
        logic [31:0] off;
        longint bstart, bsize, bend;
        int slot, i;
        bit join_lo, join_hi;
        off  = rel - heap_base;
        slot = -1;
        for (int r = NREC - 1; r >= 0; r--)
            if (blk_live[r] && blk_addr[r] == off) slot = r;
        if (slot < 0) return make_reply('0, ST_UNKNOWN);
        bstart = blk_addr[slot] - blk_adj[slot];
        bsize  = blk_len[slot];
        bend   = bstart + bsize;
        i = 0;
        while (i < free_count && free_start[i] < bend) i++;
        join_lo = (i > 0) && (free_start[i-1] + free_len[i-1] == bstart);
        join_hi = (i < free_count) && (free_start[i] == bend);
        if (join_lo && join_hi) begin
            free_len[i-1] += bsize + free_len[i];
            drop_segment(i);
        end else if (join_lo) begin
            free_len[i-1] += bsize;
        end else if (join_hi) begin
            free_start[i] = bstart;
            free_len[i]  += bsize;
        end else begin
            if (free_count >= NSEG) return make_reply('0, ST_FULL);
            for (int k = free_count; k > i; k--) begin
                free_start[k] = free_start[k-1];
                free_len[k]   = free_len[k-1];
            end
            free_start[i] = bstart;
            free_len[i]   = bsize;
            free_count++;
        end
        blk_live[slot] = 1'b0;
        bytes_held -= bsize;
        blocks_held--;
        return make_reply('0, ST_OK);
    endfunction

    // Track register writes, request beats and result beats.
    always @(posedge i_clk) begin
        t_heap_reply want;
        if (!i_rst_n) begin
            heap_base = '0;
            heap_size = 25'd16777216;
            rebuild_heap();
            expected_replies.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_REGION_BASE) heap_base = i_cfg_data;
                else heap_size = i_cfg_data[24:0];
                rebuild_heap();
            end
            if (i_req.valid && i_req.ready) begin
                if (t_op'(i_req.op) == OP_ALLOC)
                    expected_replies.push_back(
                        predict_alloc(i_req.request_bytes, i_req.align_bytes));
                else
                    expected_replies.push_back(predict_release(i_req.release_address));
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result beat with nothing expected: addr %h status %0d",
                             $time, i_res.granted_address, i_res.status);
                    o_errors++;
                end else begin
                    want = expected_replies.pop_front();
                    if (want.addr !== i_res.granted_address || want.status !== i_res.status ||
                        want.in_use !== i_res.bytes_in_use || want.live !== i_res.live_count) begin
                        $display("%0t: mismatch expected addr %h status %0d used %0d live %0d",
                                 $time, want.addr, want.status, want.in_use, want.live);
                        $display("%0t:          actual   addr %h status %0d used %0d live %0d",
                                 $time, i_res.granted_address, i_res.status,
                                 i_res.bytes_in_use, i_res.live_count);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Top of the allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import ffha_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    pending;
    int                    errors;
    bit                    idling = 1'b1;
    int                    stall_left = 0;
    logic [31:0]           live_addrs[$];
    t_op                   sent_ops[$];
    int                    n_ok, n_nofit, n_full, n_unknown;

    ffha_req_if req_ch ();
    ffha_res_if res_ch ();

    always #4 i_clk = ~i_clk;

    first_fit_heap_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    heap_predictor_check i_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_req(req_ch), .i_res(res_ch),
        .o_pending(pending), .o_errors(errors)
    );

    // Receiver stalls in short random bursts.
    initial res_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            res_ch.ready = 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = int'($urandom_range(0, 2));
            res_ch.ready = 1'b0;
        end else begin
            res_ch.ready = 1'b1;
        end
    end

    // Count the reply statuses and keep the granted addresses so that releases can name live blocks.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) sent_ops.push_back(t_op'(req_ch.op));
            if (res_ch.valid && res_ch.ready && sent_ops.size() > 0) begin
                case (t_status'(res_ch.status))
                    ST_OK: n_ok++;
                    ST_NOFIT: n_nofit++;
                    ST_FULL: n_full++;
                    default: n_unknown++;
                endcase
                if (sent_ops.pop_front() == OP_ALLOC && t_status'(res_ch.status) == ST_OK)
                    live_addrs.push_back(res_ch.granted_address);
            end
        end
    end

    task automatic send_beat(t_op op, logic [23:0] nbytes, logic [7:0] align,
                             logic [31:0] rel);
        int gap;
        if (idling && $urandom_range(0, 4) == 0) begin
            gap = int'($urandom_range(1, 3));
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.op = op;
        req_ch.request_bytes = nbytes;
        req_ch.align_bytes = align;
        req_ch.release_address = rel;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic new_region(logic [31:0] base, logic [31:0] size);
        settle();
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_REGION_SIZE, size);
        live_addrs.delete();
    endtask

    // Random mix: mostly allocations and releases of live blocks, some noise.
    task automatic random_phase(int count, int max_req);
        int pick, roll;
        logic [7:0] align;
        logic [23:0] nbytes;
        for (int n = 0; n < count; n++) begin
            roll = int'($urandom_range(0, 99));
            if (roll < 40 && live_addrs.size() > 0) begin
                pick = int'($urandom_range(0, live_addrs.size() - 1));
                send_beat(OP_FREE, 24'($urandom), 8'($urandom), live_addrs[pick]);
                live_addrs.delete(pick);
            end else if (roll < 45) begin
                send_beat(OP_FREE, 24'($urandom), 8'($urandom), $urandom);
            end else begin
                if ($urandom_range(0, 4) == 0) align = 8'($urandom_range(0, 255));
                else align = 8'd1 << $urandom_range(0, 7);
                if ($urandom_range(0, 29) == 0) nbytes = 24'($urandom_range(0, 24'hFFFFFF));
                else nbytes = 24'($urandom_range(1, max_req));
                send_beat(OP_ALLOC, nbytes, align, $urandom);
            end
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.align_bytes = '0;
        req_ch.release_address = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of sizes and alignments on the reset region.
        send_beat(OP_ALLOC, 24'hFFFFFF, 8'd128, '0);
        send_beat(OP_ALLOC, 24'd0, 8'd1, '0);
        send_beat(OP_ALLOC, 24'd1, 8'd0, '0);
        send_beat(OP_ALLOC, 24'd100, 8'd3, '0);
        send_beat(OP_ALLOC, 24'd1, 8'd128, '0);
        send_beat(OP_ALLOC, 24'd1000, 8'd255, '0);
        send_beat(OP_FREE, '0, '0, 32'hFFFFFFFF);
        send_beat(OP_FREE, '0, '0, 32'h0);
        settle();
        send_beat(OP_FREE, '0, '0, live_addrs[1]);
        send_beat(OP_FREE, '0, '0, live_addrs[1]);
        send_beat(OP_FREE, '0, '0, live_addrs[3]);
        send_beat(OP_FREE, '0, '0, live_addrs[0]);
        send_beat(OP_FREE, '0, '0, live_addrs[2]);
        send_beat(OP_FREE, '0, '0, live_addrs[4]);
        live_addrs.delete();
        // A request that takes the whole region without a split.
        send_beat(OP_ALLOC, 24'd16777200, 8'd1, '0);
        settle();
        send_beat(OP_FREE, '0, '0, live_addrs[0]);
        live_addrs.delete();

        new_region(32'h1000_0003, 32'd4096);
        random_phase(350, 200);
        new_region(32'hFFFF_FF00, 32'd2048);
        random_phase(300, 120);
        new_region(32'hFFFF_FFFF, 32'd1);
        random_phase(60, 40);
        new_region(32'h0000_0000, 32'h01FF_FFFF);
        random_phase(250, 24'hFFFFFF);
        new_region($urandom, 32'd600);
        random_phase(300, 60);
        // Closing stretch without any idling.
        new_region(32'h1234_5678, 32'd8192);
        idling = 1'b0;
        random_phase(400, 400);

        settle();
        $display("Covered %0d ok, %0d no-fit, %0d table-full and %0d unknown-release replies",
                 n_ok, n_nofit, n_full, n_unknown);
        $display("across seven region settings, including wrapped, tiny and oversized regions.");
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #8ms;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
